// ===== rtl/core/slrng_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrng_pkg
// Shared types, constants and helpers of the subtractive lagged RNG.
// ----------------------------------------------------------------------------
package slrng_pkg;

  localparam int TABLE_LEN   = 55;
  localparam int IDX_W       = $clog2(TABLE_LEN);
  localparam int WORD_W      = 32;
  localparam int BASE_W      = 31;
  localparam int BYTE_W      = 8;
  localparam int FILL_STRIDE = 21;
  localparam int MIX_OFFSET  = 30;
  localparam int MIX_PASSES  = 4;
  localparam int BACK_RESET  = 21;
  localparam int FILL_COUNT  = TABLE_LEN - 1;
  localparam int MIX_COUNT   = MIX_PASSES * TABLE_LEN;
  localparam int CNT_W       = $clog2(MIX_COUNT);

  localparam logic [BASE_W-1:0] BASE_RESET = BASE_W'(161803398);
  localparam logic [WORD_W-1:0] FIX_ADD    = 32'h7FFF_FFFF;
  localparam logic [WORD_W-1:0] SEED_MIN   = 32'h8000_0000;

  localparam logic OP_RESEED = 1'b0;
  localparam logic OP_DRAW   = 1'b1;

  // datapath operations, one per microcode step
  typedef enum logic [3:0] {
    DP_NONE,
    DP_SEED_INIT,
    DP_FILL,
    DP_MIX_INIT,
    DP_MIX_RD,
    DP_MIX_WR,
    DP_SEED_END,
    DP_DRAW_RD,
    DP_DRAW_WR
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   accept;
  } ctrl_t;

  typedef struct packed {
    logic op_draw;
    logic cnt_zero;
    logic out_free;
  } stat_t;

  // wrapping a - b, then fold a negative result back by 2^31-1
  function automatic logic [WORD_W-1:0] sub_fix(input logic [WORD_W-1:0] a,
                                                input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] d;
    d = a - b;
    if (d[WORD_W-1]) begin
      d = d + FIX_ADD;
    end
    return d;
  endfunction

  // next ring position, 1..TABLE_LEN
  function automatic logic [IDX_W-1:0] ring_next(input logic [IDX_W-1:0] pos);
    logic [IDX_W-1:0] n;
    if (pos >= IDX_W'(TABLE_LEN)) begin
      n = IDX_W'(1);
    end else begin
      n = pos + IDX_W'(1);
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/slrng_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrng_if
// Valid/ready channels for request items and sample items.
// ----------------------------------------------------------------------------
interface slrng_in_if
  import slrng_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic signed [WORD_W-1:0] seed;

  modport source (output valid, op, seed, input ready);
  modport sink   (input valid, op, seed, output ready);
endinterface

interface slrng_out_if
  import slrng_pkg::*;
  ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] sample;
  logic        [BYTE_W-1:0] sample_byte;

  modport source (output valid, sample, sample_byte, input ready);
  modport sink   (input valid, sample, sample_byte, output ready);
endinterface

// ===== rtl/core/slrng_seq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrng_seq
// Microcode sequencer: step counter, control ROM and jump logic.
// ----------------------------------------------------------------------------
module slrng_seq
  import slrng_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  input  stat_t stat,
  output logic  in_ready,
  output ctrl_t ctrl
);

  typedef logic [3:0] step_t;

  typedef enum logic [1:0] {HOLD_NONE, HOLD_IN, HOLD_OUT} hold_t;
  typedef enum logic [1:0] {JMP_NEXT, JMP_ALWAYS, JMP_DRAW, JMP_LOOP} jump_t;

  typedef struct packed {
    dp_op_t op;
    hold_t  hold;
    jump_t  jump;
    step_t  target;
  } uword_t;

  localparam step_t STEP_WAIT      = 4'd0;
  localparam step_t STEP_BRANCH    = 4'd1;
  localparam step_t STEP_SEED_INIT = 4'd2;
  localparam step_t STEP_FILL      = 4'd3;
  localparam step_t STEP_MIX_INIT  = 4'd4;
  localparam step_t STEP_MIX_RD    = 4'd5;
  localparam step_t STEP_MIX_WR    = 4'd6;
  localparam step_t STEP_SEED_END  = 4'd7;
  localparam step_t STEP_DRAW_RD   = 4'd8;
  localparam step_t STEP_DRAW_WR   = 4'd9;

  function automatic uword_t ucode_rom(input step_t s);
    uword_t w;
    unique case (s)
      STEP_WAIT:      w = '{DP_NONE,      HOLD_IN,   JMP_NEXT,   STEP_WAIT};
      STEP_BRANCH:    w = '{DP_NONE,      HOLD_NONE, JMP_DRAW,   STEP_DRAW_RD};
      STEP_SEED_INIT: w = '{DP_SEED_INIT, HOLD_NONE, JMP_NEXT,   STEP_WAIT};
      STEP_FILL:      w = '{DP_FILL,      HOLD_NONE, JMP_LOOP,   STEP_FILL};
      STEP_MIX_INIT:  w = '{DP_MIX_INIT,  HOLD_NONE, JMP_NEXT,   STEP_WAIT};
      STEP_MIX_RD:    w = '{DP_MIX_RD,    HOLD_NONE, JMP_NEXT,   STEP_WAIT};
      STEP_MIX_WR:    w = '{DP_MIX_WR,    HOLD_NONE, JMP_LOOP,   STEP_MIX_RD};
      STEP_SEED_END:  w = '{DP_SEED_END,  HOLD_NONE, JMP_ALWAYS, STEP_WAIT};
      STEP_DRAW_RD:   w = '{DP_DRAW_RD,   HOLD_NONE, JMP_NEXT,   STEP_WAIT};
      STEP_DRAW_WR:   w = '{DP_DRAW_WR,   HOLD_OUT,  JMP_ALWAYS, STEP_WAIT};
      default:        w = '{DP_NONE,      HOLD_NONE, JMP_ALWAYS, STEP_WAIT};
    endcase
    return w;
  endfunction

  step_t  step_r, step_nxt;
  uword_t uw;
  logic   stall;
  logic   taken;

  always_comb begin
    uw       = ucode_rom(step_r);
    stall    = ((uw.hold == HOLD_IN) && !in_valid) ||
               ((uw.hold == HOLD_OUT) && !stat.out_free);
    in_ready = (uw.hold == HOLD_IN);

    case (uw.jump)
      JMP_NEXT:   taken = 1'b0;
      JMP_ALWAYS: taken = 1'b1;
      JMP_DRAW:   taken = stat.op_draw;
      JMP_LOOP:   taken = !stat.cnt_zero;
      default:    taken = 1'b0;
    endcase

    ctrl.op     = stall ? DP_NONE : uw.op;
    ctrl.accept = in_ready && in_valid;

    if (stall) begin
      step_nxt = step_r;
    end else if (taken) begin
      step_nxt = uw.target;
    end else begin
      step_nxt = step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    step_r <= STEP_DRAW_WR)
    else $error("sequencer step outside program");

  a_accept_branch: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.accept |=> (step_r == STEP_BRANCH))
    else $error("accepted item not followed by dispatch");

  a_draw_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == DP_DRAW_WR) |-> stat.out_free)
    else $error("draw result issued into a full output register");

endmodule

// ===== rtl/core/slrng_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrng_dp
// Datapath: lag table memory, fill and mix registers, ring indices and the
// output register.
// ----------------------------------------------------------------------------
module slrng_dp
  import slrng_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  ctrl_t             ctrl,
  input  logic              in_op,
  input  logic [WORD_W-1:0] in_seed,
  input  logic              cfg_we,
  input  logic [BASE_W-1:0] cfg_wdata,
  input  logic              out_ready,
  output stat_t             stat,
  output logic              out_valid,
  output logic [WORD_W-1:0] out_sample
);

  logic [WORD_W-1:0]    mem [TABLE_LEN];
  logic [TABLE_LEN-1:0] vld_r;

  logic [BASE_W-1:0] seed_base_r;
  logic              op_r;
  logic [WORD_W-1:0] seed_r;
  logic [WORD_W-1:0] prev_r, cur_r;
  logic [IDX_W-1:0]  p_r, p_nxt;
  logic [CNT_W-1:0]  cnt_r;
  logic [IDX_W-1:0]  front_r, back_r;
  logic [IDX_W-1:0]  front_nxt, back_nxt;
  logic [WORD_W-1:0] rd_a_r, rd_b_r;
  logic              out_valid_r;
  logic [WORD_W-1:0] sample_r;

  logic [WORD_W-1:0] mag;
  logic [WORD_W-1:0] seed_val;
  logic [WORD_W-1:0] fix_val;
  logic [IDX_W:0]    fill_sum;
  logic [IDX_W:0]    mix_sum;
  logic [IDX_W-1:0]  mix_q;
  logic              mem_we;
  logic              mem_re;
  logic [IDX_W-1:0]  waddr, ra, rb;
  logic [WORD_W-1:0] wdata;

  always_comb begin
    if (seed_r == SEED_MIN) begin
      mag = FIX_ADD;
    end else if (seed_r[WORD_W-1]) begin
      mag = -seed_r;
    end else begin
      mag = seed_r;
    end
    seed_val = {1'b0, seed_base_r} - mag;
    fix_val  = sub_fix(rd_a_r, rd_b_r);

    // stride walk and mix partner, both modulo the table length
    fill_sum = {1'b0, p_r} + (IDX_W+1)'(FILL_STRIDE);
    p_nxt    = (fill_sum >= (IDX_W+1)'(TABLE_LEN)) ?
               IDX_W'(fill_sum - (IDX_W+1)'(TABLE_LEN)) : IDX_W'(fill_sum);
    mix_sum  = {1'b0, p_r} + (IDX_W+1)'(MIX_OFFSET + 1);
    mix_q    = (mix_sum >= (IDX_W+1)'(TABLE_LEN)) ?
               IDX_W'(mix_sum - (IDX_W+1)'(TABLE_LEN)) : IDX_W'(mix_sum);

    front_nxt = ring_next(front_r);
    back_nxt  = ring_next(back_r);

    mem_we = 1'b0;
    mem_re = 1'b0;
    waddr  = '0;
    wdata  = fix_val;
    ra     = '0;
    rb     = '0;
    unique case (ctrl.op)
      DP_SEED_INIT: begin
        mem_we = 1'b1;
        waddr  = IDX_W'(TABLE_LEN - 1);
        wdata  = seed_val;
      end
      DP_FILL: begin
        mem_we = 1'b1;
        waddr  = p_r - IDX_W'(1);
        wdata  = cur_r;
      end
      DP_MIX_RD: begin
        mem_re = 1'b1;
        ra     = p_r;
        rb     = mix_q;
      end
      DP_MIX_WR: begin
        mem_we = 1'b1;
        waddr  = p_r;
      end
      DP_DRAW_RD: begin
        mem_re = 1'b1;
        ra     = front_nxt - IDX_W'(1);
        rb     = back_nxt - IDX_W'(1);
      end
      DP_DRAW_WR: begin
        mem_we = 1'b1;
        waddr  = front_r - IDX_W'(1);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // table memory; an entry never written reads as zero
  // hold the read words while a draw waits on the output register
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (mem_re) begin
      rd_a_r <= vld_r[ra] ? mem[ra] : '0;
      rd_b_r <= vld_r[rb] ? mem[rb] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      seed_base_r <= BASE_RESET;
      front_r     <= '0;
      back_r      <= IDX_W'(BACK_RESET);
      out_valid_r <= 1'b0;
    end else begin
      if (mem_we) begin
        vld_r[waddr] <= 1'b1;
      end
      if (cfg_we) begin
        seed_base_r <= cfg_wdata;
      end
      if (ctrl.op == DP_SEED_END) begin
        front_r <= '0;
        back_r  <= IDX_W'(BACK_RESET);
      end else if (ctrl.op == DP_DRAW_RD) begin
        front_r <= front_nxt;
        back_r  <= back_nxt;
      end
      if (ctrl.op == DP_DRAW_WR) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      op_r   <= in_op;
      seed_r <= in_seed;
    end
    unique case (ctrl.op)
      DP_SEED_INIT: begin
        prev_r <= seed_val;
        cur_r  <= WORD_W'(1);
        p_r    <= IDX_W'(FILL_STRIDE);
        cnt_r  <= CNT_W'(FILL_COUNT - 1);
      end
      DP_FILL: begin
        prev_r <= cur_r;
        cur_r  <= sub_fix(prev_r, cur_r);
        p_r    <= p_nxt;
        cnt_r  <= cnt_r - CNT_W'(1);
      end
      DP_MIX_INIT: begin
        p_r   <= '0;
        cnt_r <= CNT_W'(MIX_COUNT - 1);
      end
      DP_MIX_WR: begin
        p_r   <= (p_r == IDX_W'(TABLE_LEN - 1)) ? '0 : p_r + IDX_W'(1);
        cnt_r <= cnt_r - CNT_W'(1);
      end
      DP_DRAW_WR: begin
        sample_r <= fix_val;
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

  assign stat.op_draw  = (op_r == OP_DRAW);
  assign stat.cnt_zero = (cnt_r == '0);
  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_sample    = sample_r;

  a_draw_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == DP_DRAW_WR) |=> out_valid_r)
    else $error("draw did not load the output register");

  a_fill_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.op == DP_FILL) |-> ((p_r != '0) && (p_r < IDX_W'(TABLE_LEN))))
    else $error("fill position left the ring");

  a_ring_range: assert property (@(posedge clk) disable iff (!rst_n)
    (front_r <= IDX_W'(TABLE_LEN)) && (back_r != '0) &&
    (back_r <= IDX_W'(TABLE_LEN)))
    else $error("ring index out of range");

endmodule

// ===== rtl/core/subtractive_lagged_rng.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subtractive_lagged_rng
// 55-word subtractive lagged-Fibonacci generator with reseed and draw items.
// ----------------------------------------------------------------------------
// A microcoded sequencer steps a small datapath around one 55-word table
// memory (one write port, two registered read ports). A draw item steps
// through accept, dispatch, read both lagged words, subtract and write back
// into the output register; that last step waits while the output register
// still holds an untaken sample. The sample is offered while the next item is
// already being taken. A reseed item returns nothing: accept, dispatch and
// seed init, one table write for each of the other 54 words, a mix start,
// 4 x 55 mix steps (read both words, then write), and a step that resets the
// ring indices. Table entries never written read as zero, so no clearing
// pass is needed after reset. The user must write seed_base through
// cfg_we/cfg_wdata while the block is idle; the block does not enforce it.
module subtractive_lagged_rng
  import slrng_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  slrng_in_if.sink          in_ch,
  slrng_out_if.source       out_ch,
  input  logic              cfg_we,
  input  logic [BASE_W-1:0] cfg_wdata
);

  ctrl_t             ctrl;
  stat_t             stat;
  logic              in_ready;
  logic              out_valid;
  logic [WORD_W-1:0] out_sample;

  slrng_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .stat     (stat),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  slrng_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .in_op      (in_ch.op),
    .in_seed    (in_ch.seed),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .out_ready  (out_ch.ready),
    .stat       (stat),
    .out_valid  (out_valid),
    .out_sample (out_sample)
  );

  assign in_ch.ready        = in_ready;
  assign out_ch.valid       = out_valid;
  assign out_ch.sample      = out_sample;
  assign out_ch.sample_byte = out_sample[BYTE_W-1:0];

endmodule

// ===== sim/subtractive_lagged_rng_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// subtractive_lagged_rng_test
// Self-checking bench for the 55-word subtractive lagged generator. A short
// table of reseed and draw items hits the seed extremes and the zero table
// before any reseed. Four random phases follow, each with its own seed base.
// A local model of the lag table predicts every sample, and both channels
// stall at random.
// ----------------------------------------------------------------------------
module subtractive_lagged_rng_test;
  import slrng_pkg::*;

  localparam int DIRECTED_ROWS    = 20;
  localparam int RANDOM_PER_PHASE = 483;
  localparam int RESEED_DRAIN     = 600;  // covers a trailing reseed, which returns no sample
  localparam int HOLD_AT          = 250;
  localparam int HOLD_CYCLES      = 400;

  typedef struct packed {
    logic              op;
    logic [WORD_W-1:0] seed;
    logic              typed;
    logic [WORD_W-1:0] sample;
    logic [BYTE_W-1:0] sample_byte;
  } request_row_t;

  typedef struct packed {
    logic [WORD_W-1:0] sample;
    logic [BYTE_W-1:0] sample_byte;
  } sample_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_we;
  logic [BASE_W-1:0] cfg_wdata;

  slrng_in_if  req_ch ();
  slrng_out_if smp_ch ();

  subtractive_lagged_rng u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (req_ch),
    .out_ch    (smp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // local copy of the generator; entry p-1 holds ring position p
  logic [WORD_W-1:0] lag_words [TABLE_LEN];
  logic [5:0]        pos_front;
  logic [5:0]        pos_back;
  logic [BASE_W-1:0] base_word;

  sample_t pending_samples [$];
  int      error_count   = 0;
  int      samples_taken = 0;
  bit      hold_done     = 1'b0;
  bit      in_calm       = 1'b0;
  bit      out_calm      = 1'b0;

  // draws before any reseed see the zero table, so those samples are typed in
  request_row_t directed_rows [DIRECTED_ROWS] = '{
    '{OP_DRAW,   32'hFFFF_FFFF, 1'b1, 32'h0, 8'h00},
    '{OP_DRAW,   32'h0000_0000, 1'b1, 32'h0, 8'h00},
    '{OP_DRAW,   SEED_MIN,      1'b1, 32'h0, 8'h00},
    '{OP_RESEED, 32'h0000_0000, 1'b0, 32'h0, 8'h00},
    '{OP_DRAW,   32'h5555_5555, 1'b0, 32'h0, 8'h00},
    '{OP_DRAW,   32'hAAAA_AAAA, 1'b0, 32'h0, 8'h00},
    '{OP_DRAW,   32'h0000_0000, 1'b0, 32'h0, 8'h00},
    '{OP_RESEED, SEED_MIN,      1'b0, 32'h0, 8'h00},
    '{OP_DRAW,   32'h0000_0000, 1'b0, 32'h0, 8'h00},
    '{OP_DRAW,   32'hFFFF_FFFF, 1'b0, 32'h0, 8'h00},
    '{OP_RESEED, 32'h7FFF_FFFF, 1'b0, 32'h0, 8'h00},
    '{OP_DRAW,   32'h0000_0000, 1'b0, 32'h0, 8'h00},
    '{OP_DRAW,   32'h0000_0000, 1'b0, 32'h0, 8'h00},
    '{OP_RESEED, 32'hFFFF_FFFF, 1'b0, 32'h0, 8'h00},
    '{OP_DRAW,   32'h0000_0000, 1'b0, 32'h0, 8'h00},
    '{OP_DRAW,   32'h0000_0000, 1'b0, 32'h0, 8'h00},
    '{OP_RESEED, 32'h8000_0001, 1'b0, 32'h0, 8'h00},
    '{OP_DRAW,   32'h0000_0000, 1'b0, 32'h0, 8'h00},
    '{OP_RESEED, 32'h0000_0001, 1'b0, 32'h0, 8'h00},
    '{OP_DRAW,   32'h0000_0000, 1'b0, 32'h0, 8'h00}
  };

  // wrapping difference, folded by 2^31-1 when the sign bit comes out set
  function automatic logic [WORD_W-1:0] fold_diff(input logic [WORD_W-1:0] a,
                                                  input logic [WORD_W-1:0] b);
    logic [WORD_W-1:0] d;
    d = a - b;
    if (d[WORD_W-1]) begin
      d = d + FIX_ADD;
    end
    return d;
  endfunction

  function automatic void clear_lag_words();
    for (int i = 0; i < TABLE_LEN; i++) begin
      lag_words[i] = '0;
    end
    pos_front = 6'd0;
    pos_back  = 6'(BACK_RESET);
    base_word = BASE_RESET;
  endfunction

  function automatic void reseed_lag_words(input logic [WORD_W-1:0] seed_bits);
    logic [WORD_W-1:0] mag;
    logic [WORD_W-1:0] cur;
    logic [WORD_W-1:0] prev;
    int p;
    int q;
    if (seed_bits == SEED_MIN) begin
      mag = 32'h7FFF_FFFF;
    end else if (seed_bits[WORD_W-1]) begin
      mag = -seed_bits;
    end else begin
      mag = seed_bits;
    end
    prev = {1'b0, base_word} - mag;
    lag_words[TABLE_LEN-1] = prev;
    cur = 32'd1;
    for (int i = 1; i < TABLE_LEN; i++) begin
      p = (FILL_STRIDE * i) % TABLE_LEN;
      lag_words[p-1] = cur;
      cur = fold_diff(prev, cur);
      prev = lag_words[p-1];
    end
    for (int pass = 0; pass < MIX_PASSES; pass++) begin
      for (p = 1; p <= TABLE_LEN; p++) begin
        q = 1 + (p + MIX_OFFSET) % TABLE_LEN;
        lag_words[p-1] = fold_diff(lag_words[p-1], lag_words[q-1]);
      end
    end
    pos_front = 6'd0;
    pos_back  = 6'(BACK_RESET);
  endfunction

  function automatic logic [WORD_W-1:0] draw_lag_word();
    logic [5:0]        a;
    logic [5:0]        b;
    logic [WORD_W-1:0] v;
    a = (pos_front >= 6'(TABLE_LEN)) ? 6'd1 : pos_front + 6'd1;
    b = (pos_back >= 6'(TABLE_LEN)) ? 6'd1 : pos_back + 6'd1;
    v = fold_diff(lag_words[a-1], lag_words[b-1]);
    lag_words[a-1] = v;
    pos_front = a;
    pos_back  = b;
    return v;
  endfunction

  function automatic logic [WORD_W-1:0] pick_seed();
    logic [WORD_W-1:0] s;
    case ($urandom_range(0, 5))
      0: begin
        case ($urandom_range(0, 5))
          0:       s = 32'h0000_0000;
          1:       s = 32'h0000_0001;
          2:       s = 32'hFFFF_FFFF;
          3:       s = 32'h7FFF_FFFF;
          4:       s = SEED_MIN;
          default: s = 32'h8000_0001;
        endcase
      end
      1: begin
        s = 32'($urandom_range(0, 255));
        if ($urandom_range(0, 1) == 1) begin
          s = -s;
        end
      end
      default: s = $urandom;
    endcase
    return s;
  endfunction

  task automatic offer_request(input logic op, input logic [WORD_W-1:0] seed,
                               input logic typed, input logic [WORD_W-1:0] typed_sample,
                               input logic [BYTE_W-1:0] typed_byte);
    int                gap;
    logic [WORD_W-1:0] word;
    if ($urandom_range(0, 63) == 0) begin
      in_calm = ~in_calm;
    end
    gap = in_calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid = 1'b1;
    req_ch.op    = op;
    req_ch.seed  = seed;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (op == OP_RESEED) begin
      reseed_lag_words(seed);
    end else begin
      word = draw_lag_word();
      if (typed) begin
        pending_samples.push_back(sample_t'({typed_sample, typed_byte}));
      end else begin
        pending_samples.push_back(sample_t'({word, word[BYTE_W-1:0]}));
      end
    end
    @(negedge clk);
  endtask

  // drop valid, let every sample and any trailing reseed finish
  task automatic wait_idle();
    req_ch.valid = 1'b0;
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (RESEED_DRAIN) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_seed_base(input logic [BASE_W-1:0] value);
    wait_idle();
    cfg_we    = 1'b1;
    cfg_wdata = value;
    @(posedge clk);
    base_word = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic check_sample(input logic [WORD_W-1:0] sample,
                              input logic [BYTE_W-1:0] sample_byte);
    sample_t want;
    if (pending_samples.size() == 0) begin
      $error("sample: none expected, got %0d", $signed(sample));
      error_count++;
    end else begin
      want = pending_samples.pop_front();
      if (sample !== want.sample) begin
        $error("sample: expected %0d, got %0d", $signed(want.sample), $signed(sample));
        error_count++;
      end
      if (sample_byte !== want.sample_byte) begin
        $error("sample_byte: expected %0d, got %0d", want.sample_byte, sample_byte);
        error_count++;
      end
    end
  endtask

  initial begin : request_source
    logic [BASE_W-1:0] base_value;
    logic              op;
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    req_ch.valid = 1'b0;
    req_ch.op    = OP_DRAW;
    req_ch.seed  = '0;
    clear_lag_words();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      offer_request(directed_rows[i].op, directed_rows[i].seed, directed_rows[i].typed,
                    directed_rows[i].sample, directed_rows[i].sample_byte);
    end

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       base_value = '0;
        1:       base_value = '1;
        2:       base_value = BASE_W'($urandom);
        default: base_value = BASE_RESET;
      endcase
      write_seed_base(base_value);
      // open each phase with a reseed so the new base takes effect
      offer_request(OP_RESEED, pick_seed(), 1'b0, '0, '0);
      for (int n = 1; n < RANDOM_PER_PHASE; n++) begin
        op = ($urandom_range(0, 99) < 2) ? OP_RESEED : OP_DRAW;
        offer_request(op, (op == OP_RESEED) ? pick_seed() : $urandom, 1'b0, '0, '0);
      end
    end

    wait_idle();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin : sample_sink
    int gap;
    smp_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      // hold off once for a long stretch so the block backs up into its input
      if (!hold_done && samples_taken >= HOLD_AT) begin
        smp_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 63) == 0) begin
        out_calm = ~out_calm;
      end
      gap = out_calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        smp_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      smp_ch.ready = 1'b1;
      @(posedge clk);
      while (!smp_ch.valid) @(posedge clk);
      check_sample(smp_ch.sample, smp_ch.sample_byte);
      samples_taken++;
      @(negedge clk);
    end
  end

  initial begin : run_limit
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
